// File: hw/rtl/gcd_lcm_by_prime_factors_defines.svh
// Assertion macros used by the checker file of the gcd/lcm block.
`ifndef GCD_LCM_BY_PRIME_FACTORS_DEFINES_SVH
`define GCD_LCM_BY_PRIME_FACTORS_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define GCDL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gcdl same-cycle check failed");

// Next-cycle implication, off while reset is asserted.
`define GCDL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gcdl next-cycle check failed");

`endif

// File: hw/rtl/gcdl_pkg.sv
// Package of the gcd/lcm block: widths, prime table, status codes, item type.
package gcdl_pkg;

    localparam int VAL_W            = 31;
    localparam int PRIME_W          = 9;
    localparam int PROD_W           = VAL_W + PRIME_W;
    localparam int PRIME_TABLE_SIZE = 64;
    localparam int NUM_PRIMES_DEF   = 25;

    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    localparam logic [PRIME_W-1:0] PRIME_TAB [PRIME_TABLE_SIZE] = '{
        9'd2,   9'd3,   9'd5,   9'd7,   9'd11,  9'd13,  9'd17,  9'd19,
        9'd23,  9'd29,  9'd31,  9'd37,  9'd41,  9'd43,  9'd47,  9'd53,
        9'd59,  9'd61,  9'd67,  9'd71,  9'd73,  9'd79,  9'd83,  9'd89,
        9'd97,  9'd101, 9'd103, 9'd107, 9'd109, 9'd113, 9'd127, 9'd131,
        9'd137, 9'd139, 9'd149, 9'd151, 9'd157, 9'd163, 9'd167, 9'd173,
        9'd179, 9'd181, 9'd191, 9'd193, 9'd197, 9'd199, 9'd211, 9'd223,
        9'd227, 9'd229, 9'd233, 9'd239, 9'd241, 9'd251, 9'd257, 9'd263,
        9'd269, 9'd271, 9'd277, 9'd281, 9'd283, 9'd293, 9'd307, 9'd311
    };

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO      = 2'd1,
        ST_BIG_PRIME = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    typedef struct packed {
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
        logic             zero;
    } item_t;

    // Inverse of an odd constant modulo 2^32 (Newton steps, 3 -> 96 good bits).
    function automatic logic [31:0] inv_of(input logic [31:0] p);
        logic [31:0] x;
        x = p;
        for (int k = 0; k < 5; k++)
        begin
            x = x * (32'd2 - p * x);
        end
        return x;
    endfunction

    // Largest 32-bit quotient of a multiple of p: (2^32 - 1) / p, shift-subtract.
    function automatic logic [31:0] lim_of(input logic [31:0] p);
        logic [32:0] rem;
        logic [31:0] q;
        rem = '0;
        q   = '0;
        for (int k = 31; k >= 0; k--)
        begin
            rem = {rem[31:0], 1'b1};
            if (rem >= {1'b0, p})
            begin
                rem  = rem - {1'b0, p};
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

endpackage

// File: hw/rtl/gcdl_front.sv
// Front end: accept operand pairs, flag zero operands, hold them in a two-beat queue.
module gcdl_front
    import gcdl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [VAL_W-1:0] a_value,
    input  logic [VAL_W-1:0] b_value,
    output logic             q_valid,
    output item_t            q_item,
    input  logic             q_take
);

    item_t       slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        wr_en;
    logic        rd_en;
    item_t       new_item;

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];

    assign wr_en = push && !full;
    assign rd_en = q_take && q_valid;

    // Classify on entry: a zero operand skips the factoring engine.
    always_comb
    begin
        new_item.a    = a_value;
        new_item.b    = b_value;
        new_item.zero = (a_value == '0) || (b_value == '0);
    end

    always_comb
    begin
        wr_ptr_next = wr_en ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// File: hw/rtl/gcdl_back.sv
// Back end: lockstep trial division of both operands, gcd/lcm build-up, result register.
module gcdl_back
    import gcdl_pkg::*;
#(
    parameter int NUM_PRIMES = NUM_PRIMES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  item_t            q_item,
    output logic             q_take,
    output logic             empty,
    input  logic             pop,
    output logic [VAL_W-1:0] gcd_value,
    output logic [VAL_W-1:0] lcm_value,
    output logic [1:0]       status
);

    localparam int IDX_W = (NUM_PRIMES > 1) ? $clog2(NUM_PRIMES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_PRIMES - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_CHK  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    logic [PRIME_W-1:0] prime_tab [NUM_PRIMES];
    logic [31:0]        inv_tab   [NUM_PRIMES];
    logic [31:0]        lim_tab   [NUM_PRIMES];

    for (genvar gi = 0; gi < NUM_PRIMES; gi++)
    begin : g_tab
        localparam logic [31:0] INV = inv_of(32'(PRIME_TAB[gi]));
        localparam logic [31:0] LIM = lim_of(32'(PRIME_TAB[gi]));
        assign prime_tab[gi] = PRIME_TAB[gi];
        assign inv_tab[gi]   = INV;
        assign lim_tab[gi]   = LIM;
    end

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [VAL_W-1:0]   va_reg, va_next;
    logic [VAL_W-1:0]   vb_reg, vb_next;
    logic [VAL_W-1:0]   g_reg, g_next;
    logic [VAL_W-1:0]   l_reg, l_next;
    logic               ovf_reg, ovf_next;
    logic [31:0]        qa_reg, qa_next;
    logic [31:0]        qb_reg, qb_next;
    logic [PROD_W-1:0]  gp_reg, gp_next;
    logic [PROD_W-1:0]  lp_reg, lp_next;
    status_t            res_st_reg, res_st_next;
    logic [VAL_W-1:0]   res_g_reg, res_g_next;
    logic [VAL_W-1:0]   res_l_reg, res_l_next;
    logic               out_valid_reg, out_valid_next;
    status_t            out_st_reg, out_st_next;
    logic [VAL_W-1:0]   out_g_reg, out_g_next;
    logic [VAL_W-1:0]   out_l_reg, out_l_next;

    logic [PRIME_W-1:0] prime;
    logic [31:0]        inv;
    logic [31:0]        lim;
    logic               is_two;
    logic               da;
    logic               db;
    logic               both_one;

    assign prime    = prime_tab[idx_reg];
    assign inv      = inv_tab[idx_reg];
    assign lim      = lim_tab[idx_reg];
    assign is_two   = (idx_reg == '0);
    // Odd primes: p divides v exactly when v * p^-1 mod 2^32 stays at or below the limit.
    assign da       = is_two ? ~va_reg[0] : (qa_reg <= lim);
    assign db       = is_two ? ~vb_reg[0] : (qb_reg <= lim);
    assign both_one = (va_reg == VAL_W'(1)) && (vb_reg == VAL_W'(1));

    assign empty     = !out_valid_reg;
    assign gcd_value = out_g_reg;
    assign lcm_value = out_l_reg;
    assign status    = out_st_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        va_next        = va_reg;
        vb_next        = vb_reg;
        g_next         = g_reg;
        l_next         = l_reg;
        ovf_next       = ovf_reg;
        qa_next        = qa_reg;
        qb_next        = qb_reg;
        gp_next        = gp_reg;
        lp_next        = lp_reg;
        res_st_next    = res_st_reg;
        res_g_next     = res_g_reg;
        res_l_next     = res_l_reg;
        out_st_next    = out_st_reg;
        out_g_next     = out_g_reg;
        out_l_next     = out_l_reg;
        out_valid_next = out_valid_reg;
        q_take         = 1'b0;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_take = 1'b1;
                    if (q_item.zero)
                    begin
                        res_st_next = ST_ZERO;
                        res_g_next  = '0;
                        res_l_next  = '0;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        va_next    = q_item.a;
                        vb_next    = q_item.b;
                        g_next     = VAL_W'(1);
                        l_next     = VAL_W'(1);
                        ovf_next   = 1'b0;
                        idx_next   = '0;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                qa_next    = is_two ? {2'b00, va_reg[VAL_W-1:1]} : 32'({1'b0, va_reg} * inv);
                qb_next    = is_two ? {2'b00, vb_reg[VAL_W-1:1]} : 32'({1'b0, vb_reg} * inv);
                gp_next    = PROD_W'(g_reg) * PROD_W'(prime);
                lp_next    = PROD_W'(l_reg) * PROD_W'(prime);
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (both_one)
                begin
                    // Fully factored: lcm overflow decides the status.
                    res_st_next = ovf_reg ? ST_OVERFLOW : ST_OK;
                    res_g_next  = ovf_reg ? '0 : g_reg;
                    res_l_next  = ovf_reg ? '0 : l_reg;
                    state_next  = S_DONE;
                end
                else if (da || db)
                begin
                    if (da)
                    begin
                        va_next = qa_reg[VAL_W-1:0];
                    end
                    if (db)
                    begin
                        vb_next = qb_reg[VAL_W-1:0];
                    end
                    // Both divisible raises the smaller exponent, hence the gcd.
                    if (da && db)
                    begin
                        g_next = gp_reg[VAL_W-1:0];
                    end
                    if (!ovf_reg)
                    begin
                        if (lp_reg > PROD_W'(VAL_MAX))
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            l_next = lp_reg[VAL_W-1:0];
                        end
                    end
                    state_next = S_MUL;
                end
                else if (idx_reg == IDX_LAST)
                begin
                    // Residue left over after the last prime.
                    res_st_next = ST_BIG_PRIME;
                    res_g_next  = '0;
                    res_l_next  = '0;
                    state_next  = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_MUL;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next = 1'b1;
                    out_st_next    = res_st_reg;
                    out_g_next     = res_g_reg;
                    out_l_next     = res_l_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        va_reg     <= va_next;
        vb_reg     <= vb_next;
        g_reg      <= g_next;
        l_reg      <= l_next;
        ovf_reg    <= ovf_next;
        qa_reg     <= qa_next;
        qb_reg     <= qb_next;
        gp_reg     <= gp_next;
        lp_reg     <= lp_next;
        res_st_reg <= res_st_next;
        res_g_reg  <= res_g_next;
        res_l_reg  <= res_l_next;
        out_st_reg <= out_st_next;
        out_g_reg  <= out_g_next;
        out_l_reg  <= out_l_next;
    end

endmodule

// File: hw/rtl/gcd_lcm_by_prime_factors.sv
// Top level of the gcd/lcm block: front end, two-beat queue, factoring back end.
//
// Usage: write an operand pair (a_value, b_value) with push while full is low;
// each beat returns one result beat with gcd_value, lcm_value and status
// (ok, zero operand, prime factor above the table, lcm overflow); gcd and lcm
// read zero whenever status is not ok. Read the oldest result while empty is
// low and drop it with pop. Results come back in input order.
// Flow: a zero operand goes from the queue through the back end's idle and
// done states to the result port with no trial division. Otherwise the back
// end runs trial steps (a multiply by the modular inverse of the prime, then a
// check and update), with one step per prime tried plus one each time the
// prime divides one or both operands; it stops early once both operands are
// factored down to one.
// Throughput: one pair in flight in the back end; the front queue takes up to
// two more pairs, so push keeps going while the engine works.
// Reset: queue and result register come up empty, the engine idle; nothing else.
// Stall: when pop stays low, the result register holds its beat, the engine
// parks its next result, then the queue fills and full rises.
module gcd_lcm_by_prime_factors
    import gcdl_pkg::*;
#(
    parameter int NUM_PRIMES = NUM_PRIMES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [VAL_W-1:0] a_value,
    input  logic [VAL_W-1:0] b_value,
    output logic             empty,
    input  logic             pop,
    output logic [VAL_W-1:0] gcd_value,
    output logic [VAL_W-1:0] lcm_value,
    output logic [1:0]       status
);

    // Queue handoff between front and back.
    logic  q_valid;
    logic  q_take;
    item_t q_item;

    gcdl_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .a_value (a_value),
        .b_value (b_value),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_take  (q_take)
    );

    gcdl_back #(
        .NUM_PRIMES (NUM_PRIMES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_take    (q_take),
        .empty     (empty),
        .pop       (pop),
        .gcd_value (gcd_value),
        .lcm_value (lcm_value),
        .status    (status)
    );

endmodule

// File: hw/rtl/gcdl_checker.sv
// Port-level checker of the gcd/lcm block and its bind.
`include "gcd_lcm_by_prime_factors_defines.svh"

module gcdl_checker
    import gcdl_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             push,
    input logic             full,
    input logic             empty,
    input logic             pop,
    input logic [VAL_W-1:0] gcd_value,
    input logic [VAL_W-1:0] lcm_value,
    input logic [1:0]       status
);

    `GCDL_ASSERT_IMP(a_fail_zero, clk, rst_n, !empty && (status != ST_OK), (gcd_value == '0) && (lcm_value == '0))
    `GCDL_ASSERT_IMP(a_ok_order, clk, rst_n, !empty && (status == ST_OK), (gcd_value != '0) && (gcd_value <= lcm_value))
    `GCDL_ASSERT_IMP(a_full_rise, clk, rst_n, $rose(full), $past(push))
    `GCDL_ASSERT_NXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(gcd_value) && $stable(lcm_value) && $stable(status))

endmodule

bind gcd_lcm_by_prime_factors gcdl_checker u_gcdl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .gcd_value (gcd_value),
    .lcm_value (lcm_value),
    .status    (status)
);
